// File: sv/fau_pkg.sv
// Shared types, constants and helper functions of the half/single float unit.
// Used by fau_div, float_arith_unit_half_single, fau_checker and tb_top; depends on nothing else.
package fau_pkg;

    // Format constants
    localparam int FRAC_SINGLE = 23;
    localparam int FRAC_HALF   = 10;
    localparam int EXPW_SINGLE = 8;
    localparam int EXPW_HALF   = 5;
    localparam int BIAS_SINGLE = 127;
    localparam int BIAS_HALF   = 15;
    localparam int EMIN_SINGLE = -149;
    localparam int EMIN_HALF   = -24;

    // Datapath sizes
    localparam int MANT_W    = FRAC_SINGLE + 1;   // significand with hidden one
    localparam int MAG_W     = 52;                // common magnitude frame
    localparam int DIV_STEPS = 26;                // quotient bits per divide

    // Signed internal exponent
    typedef logic signed [11:0] t_exp;

    typedef enum logic [1:0] {
        CLS_NUM  = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_INF  = 2'd2,
        CLS_NAN  = 2'd3
    } t_cls;

    typedef enum logic [2:0] {
        OP_PASS = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        RM_RTZ = 2'd0,
        RM_RNE = 2'd1,
        RM_RUP = 2'd2,
        RM_RDN = 2'd3
    } t_rm;

    typedef enum logic {
        CFG_PREC  = 1'b0,
        CFG_RMODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PATH_PASS = 2'd0,
        PATH_ADD  = 2'd1,
        PATH_MUL  = 2'd2,
        PATH_DIV  = 2'd3
    } t_path;

    // Decoded operand: value = mant * 2^(exp - 23), hidden one at bit 23
    typedef struct packed {
        t_cls              cls;
        logic              sign;
        t_exp              exp;
        logic [MANT_W-1:0] mant;
    } t_fval;

    // Data that rides alongside the divider: value = mag * 2^q (for divides the quotient takes the place of mag)
    typedef struct packed {
        logic             is_div;
        logic             special;
        t_cls             cls;
        logic             sign;
        t_exp             q;
        logic [MAG_W-1:0] mag;
    } t_side;

    // Leading zero count of a 64-bit word, binary search
    function automatic logic [5:0] fau_lzc64(input logic [63:0] v);
        logic [63:0] t;
        logic [5:0]  n;
        t = v;
        n = '0;
        if (t[63:32] == '0) begin
            n[5] = 1'b1;
            t    = {t[31:0], 32'd0};
        end
        if (t[63:48] == '0) begin
            n[4] = 1'b1;
            t    = {t[47:0], 16'd0};
        end
        if (t[63:56] == '0) begin
            n[3] = 1'b1;
            t    = {t[55:0], 8'd0};
        end
        if (t[63:60] == '0) begin
            n[2] = 1'b1;
            t    = {t[59:0], 4'd0};
        end
        if (t[63:62] == '0) begin
            n[1] = 1'b1;
            t    = {t[61:0], 2'd0};
        end
        if (!t[63]) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    // Unpack a raw encoding; subnormals come out normalized
    function automatic t_fval fau_decode(input logic [31:0] raw, input logic prec);
        t_fval       r;
        logic [22:0] frac;
        logic [7:0]  ef;
        logic        ef_max;
        t_exp        bias;
        logic [5:0]  lz;
        if (prec) begin
            frac   = raw[FRAC_SINGLE-1:0];
            ef     = raw[30:23];
            r.sign = raw[31];
            ef_max = &raw[30:23];
            bias   = t_exp'(BIAS_SINGLE);
        end else begin
            frac   = {raw[FRAC_HALF-1:0], 13'd0};
            ef     = {3'd0, raw[14:10]};
            r.sign = raw[15];
            ef_max = &raw[14:10];
            bias   = t_exp'(BIAS_HALF);
        end
        lz     = fau_lzc64({frac, {41{1'b1}}});
        r.cls  = CLS_NUM;
        r.exp  = '0;
        r.mant = '0;
        if (ef_max) begin
            r.cls = (frac != '0) ? CLS_NAN : CLS_INF;
        end else if (ef == '0) begin
            if (frac == '0) begin
                r.cls = CLS_ZERO;
            end else begin
                r.mant = 24'({1'b0, frac} << (lz + 6'd1));
                r.exp  = t_exp'(0) - bias - t_exp'({6'd0, lz});
            end
        end else begin
            r.mant = {1'b1, frac};
            r.exp  = t_exp'({4'd0, ef}) - bias;
        end
        return r;
    endfunction

endpackage

// File: sv/fau_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Carries a t_side record from fau_pkg alongside each request.
module fau_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [fau_pkg::MANT_W-1:0]     i_ma,
    input  logic [fau_pkg::MANT_W-1:0]     i_mb,
    input  fau_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [fau_pkg::DIV_STEPS-1:0]  o_quot,
    output logic                           o_rem_nz,
    output fau_pkg::t_side                 o_side
);

    localparam int N = fau_pkg::DIV_STEPS;
    localparam int W = fau_pkg::MANT_W;

    logic                r_valid [0:N];
    logic [W:0]          r_rem   [0:N];
    logic [W-1:0]        r_dvs   [0:N];
    logic [N-1:0]        r_quot  [0:N];
    fau_pkg::t_side      r_side  [0:N];

    // Entry stage: remainder starts at the dividend significand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= {1'b0, i_ma};
            r_dvs[0]  <= i_mb;
            r_quot[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // One compare/subtract per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic         ge;
        logic [W:0]   rn;
        assign ge = (r_rem[k] >= {1'b0, r_dvs[k]});
        assign rn = ge ? (r_rem[k] - {1'b0, r_dvs[k]}) : r_rem[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= {rn[W-1:0], 1'b0};
                r_dvs[k+1]  <= r_dvs[k];
                r_quot[k+1] <= {r_quot[k][N-2:0], ge};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid  = r_valid[N];
    assign o_quot   = r_quot[N];
    assign o_rem_nz = (r_rem[N] != '0);
    assign o_side   = r_side[N];

endmodule

// File: sv/float_arith_unit_half_single.sv
// Top level of the binary16/binary32 add, subtract, multiply, divide unit.
// Depends on fau_pkg and fau_div.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+--------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | tuser opcode, tdata A and B
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | tuser class, tdata sign/exp/frac
//  cfg       | in        | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// Every opcode takes the same path; one request enters per cycle unless the output stalls.
// The pipe's depth comes from the divider, which resolves one quotient bit per stage
// (26 stages); the other opcodes ride alongside it.
// Reset clears the valid bits and sets single precision, nearest-even.
// When the output register holds an unaccepted result the whole pipe freezes.
module float_arith_unit_half_single (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata: [31:0] operand_a, [63:32] operand_b
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    // s_axis tuser: [2:0] opcode
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // m_axis tdata: [0] result_sign, [9:1] result_exponent, [32:10] result_fraction
    output logic [39:0] o_m_axis_tdata,
    // m_axis tuser: [1:0] result_class
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    localparam int W  = fau_pkg::MANT_W;
    localparam int MW = fau_pkg::MAG_W;
    localparam int AW = MW - 1;   // aligned adder operand width

    typedef struct packed {
        fau_pkg::t_fval a;
        fau_pkg::t_fval b;
        logic [2:0]     op;
    } t_s1;

    typedef struct packed {
        fau_pkg::t_path path;
        logic           special;
        fau_pkg::t_cls  sp_cls;
        logic           sign;
        logic [W-1:0]   xm;
        logic [W-1:0]   ym;
        logic           xs;
        logic           ys;
        fau_pkg::t_exp  xe;
        logic [5:0]     shamt;
        logic [2*W-1:0] prod;
        fau_pkg::t_exp  qm;
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        fau_pkg::t_exp  qd;
    } t_s2;

    typedef struct packed {
        fau_pkg::t_path path;
        logic           special;
        fau_pkg::t_cls  sp_cls;
        logic           sign;
        logic           xs;
        logic           ys;
        fau_pkg::t_exp  xe;
        logic [AW-1:0]  xa;
        logic [AW-1:0]  ya;
        logic [2*W-1:0] prod;
        fau_pkg::t_exp  qm;
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        fau_pkg::t_exp  qd;
    } t_s3;

    typedef struct packed {
        logic          special;
        fau_pkg::t_cls cls;
        logic          sign;
        fau_pkg::t_exp q;
        logic [MW-1:0] mag;
        logic          st;
        logic [5:0]    lz;
    } t_s5;

    typedef struct packed {
        logic          special;
        fau_pkg::t_cls cls;
        logic          sign;
        fau_pkg::t_exp e;
        logic [MW-1:0] mn;
        logic          st;
    } t_s6;

    // Configuration
    logic          r_prec;
    fau_pkg::t_rm  r_rm;

    // Pipeline registers
    logic  r_s1_valid, r_s2_valid, r_s3_valid, r_s5_valid, r_s6_valid, r_out_valid;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_s3   r_s3, n_s3;
    t_s5   r_s5, n_s5;
    t_s6   r_s6, n_s6;
    fau_pkg::t_cls r_out_cls, n_out_cls;
    logic          r_out_sign, n_out_sign;
    logic [8:0]    r_out_exp, n_out_exp;
    logic [22:0]   r_out_frac, n_out_frac;

    logic en;

    // Divider interface
    fau_pkg::t_side           div_side_in, div_side_out;
    logic                     div_valid;
    logic [fau_pkg::DIV_STEPS-1:0] div_quot;
    logic                     div_rem_nz;

    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= 1'b1;
            r_rm   <= fau_pkg::RM_RNE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fau_pkg::CFG_PREC:  r_prec <= i_cfg_data[0];
                fau_pkg::CFG_RMODE: r_rm   <= fau_pkg::t_rm'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Stage 1: decode both operands
    always_comb begin
        n_s1.a  = fau_pkg::fau_decode(i_s_axis_tdata[31:0], r_prec);
        n_s1.b  = fau_pkg::fau_decode(i_s_axis_tdata[63:32], r_prec);
        n_s1.op = i_s_axis_tuser;
    end

    // Stage 2: special operands, operand order for add, product for multiply, scale for divide
    always_comb begin
        fau_pkg::t_fval a, b, x, y;
        logic           x_is_a;
        fau_pkg::t_exp  ediff;
        a = r_s1.a;
        b = r_s1.b;
        if (r_s1.op == fau_pkg::OP_SUB) begin
            b.sign = ~b.sign;
        end
        if (a.cls == fau_pkg::CLS_ZERO) begin
            x_is_a = 1'b0;
        end else if (b.cls == fau_pkg::CLS_ZERO) begin
            x_is_a = 1'b1;
        end else begin
            x_is_a = (a.exp >= b.exp);
        end
        x     = x_is_a ? a : b;
        y     = x_is_a ? b : a;
        ediff = x.exp - y.exp;

        n_s2.path    = fau_pkg::PATH_PASS;
        n_s2.special = 1'b0;
        n_s2.sp_cls  = fau_pkg::CLS_NUM;
        n_s2.sign    = a.sign ^ r_s1.b.sign;
        n_s2.xm      = x.mant;
        n_s2.ym      = y.mant;
        n_s2.xs      = x.sign;
        n_s2.ys      = y.sign;
        n_s2.xe      = x.exp;
        n_s2.shamt   = (ediff > fau_pkg::t_exp'(AW)) ? 6'(AW) : ediff[5:0];
        n_s2.prod    = a.mant * r_s1.b.mant;
        n_s2.qm      = a.exp + r_s1.b.exp - fau_pkg::t_exp'(2 * fau_pkg::FRAC_SINGLE);
        n_s2.ma      = a.mant;
        n_s2.mb      = r_s1.b.mant;
        n_s2.qd      = a.exp - r_s1.b.exp - fau_pkg::t_exp'(fau_pkg::DIV_STEPS - 1);

        case (r_s1.op)
            fau_pkg::OP_ADD, fau_pkg::OP_SUB: begin
                n_s2.path = fau_pkg::PATH_ADD;
                if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_NAN;
                end else if (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_INF) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = (a.sign == b.sign) ? fau_pkg::CLS_INF : fau_pkg::CLS_NAN;
                    n_s2.sign    = a.sign;
                end else if (a.cls == fau_pkg::CLS_INF) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_INF;
                    n_s2.sign    = a.sign;
                end else if (b.cls == fau_pkg::CLS_INF) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_INF;
                    n_s2.sign    = b.sign;
                end else if (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_ZERO) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_ZERO;
                    n_s2.sign    = (a.sign == b.sign) ? a.sign : (r_rm == fau_pkg::RM_RDN);
                end
            end
            fau_pkg::OP_MUL: begin
                n_s2.path = fau_pkg::PATH_MUL;
                if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN
                    || (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_ZERO)
                    || (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_INF)) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_NAN;
                end else if (a.cls == fau_pkg::CLS_INF || b.cls == fau_pkg::CLS_INF) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_INF;
                end else if (a.cls == fau_pkg::CLS_ZERO || b.cls == fau_pkg::CLS_ZERO) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_ZERO;
                end
            end
            fau_pkg::OP_DIV: begin
                n_s2.path = fau_pkg::PATH_DIV;
                if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN
                    || (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_ZERO)
                    || (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_INF)) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_NAN;
                end else if (a.cls == fau_pkg::CLS_INF || b.cls == fau_pkg::CLS_ZERO) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_INF;
                end else if (a.cls == fau_pkg::CLS_ZERO || b.cls == fau_pkg::CLS_INF) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = fau_pkg::CLS_ZERO;
                end
            end
            default: begin
                // pass A, also unused opcodes
                n_s2.sign = a.sign;
                n_s2.xm   = a.mant;
                n_s2.xe   = a.exp;
                if (a.cls != fau_pkg::CLS_NUM) begin
                    n_s2.special = 1'b1;
                    n_s2.sp_cls  = a.cls;
                end
            end
        endcase
    end

    // Stage 3: align the addend with the smaller exponent, jamming shifted-out bits into bit 0
    always_comb begin
        logic [W+AW-1:0] wide;
        wide         = {r_s2.ym, {AW{1'b0}}} >> r_s2.shamt;
        n_s3.path    = r_s2.path;
        n_s3.special = r_s2.special;
        n_s3.sp_cls  = r_s2.sp_cls;
        n_s3.sign    = r_s2.sign;
        n_s3.xs      = r_s2.xs;
        n_s3.ys      = r_s2.ys;
        n_s3.xe      = r_s2.xe;
        n_s3.xa      = {r_s2.xm, {(AW-W){1'b0}}};
        n_s3.ya      = wide[W+AW-1:W] | {{(AW-1){1'b0}}, |wide[W-1:0]};
        n_s3.prod    = r_s2.prod;
        n_s3.qm      = r_s2.qm;
        n_s3.ma      = r_s2.ma;
        n_s3.mb      = r_s2.mb;
        n_s3.qd      = r_s2.qd;
    end

    // Stage 4: add/subtract, gather magnitude and scale for every path
    always_comb begin
        logic [MW-1:0] sum, dxy, dyx;
        sum = {1'b0, r_s3.xa} + {1'b0, r_s3.ya};
        dxy = {1'b0, r_s3.xa} - {1'b0, r_s3.ya};
        dyx = {1'b0, r_s3.ya} - {1'b0, r_s3.xa};

        div_side_in.is_div  = 1'b0;
        div_side_in.special = r_s3.special;
        div_side_in.cls     = r_s3.sp_cls;
        div_side_in.sign    = r_s3.sign;
        div_side_in.q       = '0;
        div_side_in.mag     = '0;
        if (!r_s3.special) begin
            case (r_s3.path)
                fau_pkg::PATH_ADD: begin
                    div_side_in.q = r_s3.xe - fau_pkg::t_exp'(AW - 1);
                    if (r_s3.xs == r_s3.ys) begin
                        div_side_in.mag  = sum;
                        div_side_in.sign = r_s3.xs;
                    end else if (dxy == '0) begin
                        // exact cancellation
                        div_side_in.special = 1'b1;
                        div_side_in.cls     = fau_pkg::CLS_ZERO;
                        div_side_in.sign    = (r_rm == fau_pkg::RM_RDN);
                    end else if (!dxy[MW-1]) begin
                        div_side_in.mag  = dxy;
                        div_side_in.sign = r_s3.xs;
                    end else begin
                        div_side_in.mag  = dyx;
                        div_side_in.sign = r_s3.ys;
                    end
                end
                fau_pkg::PATH_MUL: begin
                    div_side_in.mag = {{(MW-2*W){1'b0}}, r_s3.prod};
                    div_side_in.q   = r_s3.qm;
                end
                fau_pkg::PATH_DIV: begin
                    div_side_in.is_div = 1'b1;
                    div_side_in.q      = r_s3.qd;
                end
                default: begin
                    div_side_in.mag = {r_s3.xa, 1'b0};
                    div_side_in.q   = r_s3.xe - fau_pkg::t_exp'(MW - 1);
                end
            endcase
        end
    end

    fau_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s3_valid),
        .i_ma     (r_s3.ma),
        .i_mb     (r_s3.mb),
        .i_side   (div_side_in),
        .o_valid  (div_valid),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz),
        .o_side   (div_side_out)
    );

    // Stage 5: pick the quotient for divides, count leading zeros
    always_comb begin
        n_s5.special = div_side_out.special;
        n_s5.cls     = div_side_out.cls;
        n_s5.sign    = div_side_out.sign;
        n_s5.q       = div_side_out.q;
        n_s5.mag     = div_side_out.is_div
                       ? {{(MW-fau_pkg::DIV_STEPS){1'b0}}, div_quot} : div_side_out.mag;
        n_s5.st      = div_side_out.is_div && div_rem_nz;
        n_s5.lz      = fau_pkg::fau_lzc64({n_s5.mag, {(64-MW){1'b1}}});
    end

    // Stage 6: normalize so the leading one sits at the top bit
    always_comb begin
        n_s6.special = r_s5.special;
        n_s6.cls     = r_s5.cls;
        n_s6.sign    = r_s5.sign;
        n_s6.st      = r_s5.st;
        n_s6.mn      = r_s5.mag << r_s5.lz;
        n_s6.e       = r_s5.q + fau_pkg::t_exp'(MW - 1) - fau_pkg::t_exp'({6'd0, r_s5.lz});
    end

    // Stage 7: round, range checks, pack result fields
    always_comb begin
        logic [W-1:0]  keep;
        logic          rb, stk, up, carry, ovf, unf, toward;
        logic [W:0]    mr;
        fau_pkg::t_exp bias, emin, e1;
        if (r_prec) begin
            keep = r_s6.mn[MW-1:MW-W];
            rb   = r_s6.mn[MW-W-1];
            stk  = (r_s6.mn[MW-W-2:0] != '0) || r_s6.st;
            bias = fau_pkg::t_exp'(fau_pkg::BIAS_SINGLE);
            emin = fau_pkg::t_exp'(fau_pkg::EMIN_SINGLE);
        end else begin
            keep = {{(W-fau_pkg::FRAC_HALF-1){1'b0}},
                    r_s6.mn[MW-1:MW-fau_pkg::FRAC_HALF-1]};
            rb   = r_s6.mn[MW-fau_pkg::FRAC_HALF-2];
            stk  = (r_s6.mn[MW-fau_pkg::FRAC_HALF-3:0] != '0) || r_s6.st;
            bias = fau_pkg::t_exp'(fau_pkg::BIAS_HALF);
            emin = fau_pkg::t_exp'(fau_pkg::EMIN_HALF);
        end
        toward = (r_rm == fau_pkg::RM_RUP && !r_s6.sign)
                 || (r_rm == fau_pkg::RM_RDN && r_s6.sign);
        case (r_rm)
            fau_pkg::RM_RNE: up = rb && (stk || keep[0]);
            fau_pkg::RM_RUP: up = (rb || stk) && !r_s6.sign;
            fau_pkg::RM_RDN: up = (rb || stk) && r_s6.sign;
            default:         up = 1'b0;
        endcase
        mr    = {1'b0, keep} + {{W{1'b0}}, up};
        carry = r_prec ? mr[W] : mr[fau_pkg::FRAC_HALF+1];
        e1    = r_s6.e + fau_pkg::t_exp'(1);
        ovf   = (r_s6.e > bias) || (carry && (r_s6.e == bias));
        unf   = (r_s6.e < emin);

        n_out_cls  = fau_pkg::CLS_NUM;
        n_out_sign = r_s6.sign;
        n_out_exp  = '0;
        n_out_frac = '0;
        if (r_s6.special) begin
            n_out_cls  = r_s6.cls;
            n_out_sign = (r_s6.cls == fau_pkg::CLS_NAN) ? 1'b0 : r_s6.sign;
        end else if (ovf) begin
            if (r_rm == fau_pkg::RM_RNE || toward) begin
                n_out_cls = fau_pkg::CLS_INF;
            end else begin
                n_out_exp  = bias[8:0];
                n_out_frac = r_prec ? {fau_pkg::FRAC_SINGLE{1'b1}}
                                    : {{(fau_pkg::FRAC_SINGLE-fau_pkg::FRAC_HALF){1'b0}},
                                       {fau_pkg::FRAC_HALF{1'b1}}};
            end
        end else if (unf) begin
            if (toward) begin
                n_out_exp = emin[8:0];
            end else begin
                n_out_cls = fau_pkg::CLS_ZERO;
            end
        end else begin
            n_out_exp = carry ? e1[8:0] : r_s6.e[8:0];
            if (!carry) begin
                n_out_frac = r_prec ? mr[fau_pkg::FRAC_SINGLE-1:0]
                                    : {{(fau_pkg::FRAC_SINGLE-fau_pkg::FRAC_HALF){1'b0}},
                                       mr[fau_pkg::FRAC_HALF-1:0]};
            end
        end
    end

    // Pipeline registers, all advancing together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_s_axis_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s5_valid  <= div_valid;
            r_s6_valid  <= r_s5_valid;
            r_out_valid <= r_s6_valid;
        end
        if (en) begin
            r_s1       <= n_s1;
            r_s2       <= n_s2;
            r_s3       <= n_s3;
            r_s5       <= n_s5;
            r_s6       <= n_s6;
            r_out_cls  <= n_out_cls;
            r_out_sign <= n_out_sign;
            r_out_exp  <= n_out_exp;
            r_out_frac <= n_out_frac;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_cls;
    assign o_m_axis_tdata  = {7'd0, r_out_frac, r_out_exp, r_out_sign};

endmodule

// File: sim/fau_checker.sv
// Scoreboard for the half/single float unit: watches the request, result and
// config channels, predicts each result and compares it field by field.
// Depends on fau_pkg for the format constants and the class, opcode, rounding mode and config codes.
`timescale 1ns / 100ps

module fau_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,
    input  logic [1:0]  i_m_axis_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int DIV_EXTRA   = 40;
    localparam int ALIGN_CAP   = 38;

    typedef struct {
        fau_pkg::t_cls cls;
        logic          sign;
        int            ex;
        logic [63:0]   mant;
    } t_num;

    typedef struct packed {
        fau_pkg::t_cls cls;
        logic          sign;
        logic [8:0]    ex;
        logic [22:0]   frac;
    } t_result;

    t_result      result_fifo[$];
    logic         prec_sel;
    fau_pkg::t_rm rmode;
    int           mismatches;

    function automatic int frac_bits();
        return prec_sel ? fau_pkg::FRAC_SINGLE : fau_pkg::FRAC_HALF;
    endfunction

    function automatic int bias();
        return prec_sel ? fau_pkg::BIAS_SINGLE : fau_pkg::BIAS_HALF;
    endfunction

    function automatic int msb_pos(logic [63:0] v);
        int p;
        p = 63;
        while (p > 0 && !v[p]) p--;
        return p;
    endfunction

    function automatic t_num mk(fau_pkg::t_cls c, logic s);
        t_num r;
        r.cls = c;
        r.sign = s;
        r.ex = 0;
        r.mant = '0;
        return r;
    endfunction

    function automatic t_num unpack_operand(logic [31:0] raw);
        int          ew;
        logic [63:0] frac;
        logic [63:0] ef;
        t_num        r;
        int          p;
        ew   = prec_sel ? fau_pkg::EXPW_SINGLE : fau_pkg::EXPW_HALF;
        frac = raw & ((64'd1 << frac_bits()) - 1);
        ef   = (raw >> frac_bits()) & ((64'd1 << ew) - 1);
        r    = mk(fau_pkg::CLS_NUM, raw[frac_bits() + ew]);
        if (ef == (64'd1 << ew) - 1)
            return mk(frac != 0 ? fau_pkg::CLS_NAN : fau_pkg::CLS_INF, r.sign);
        if (ef == 0) begin
            if (frac == 0) return mk(fau_pkg::CLS_ZERO, r.sign);
            p = msb_pos(frac);
            r.mant = frac << (frac_bits() - p);
            r.ex = 1 - bias() - (frac_bits() - p);
            return r;
        end
        r.mant = frac | (64'd1 << frac_bits());
        r.ex = int'(ef) - bias();
        return r;
    endfunction

    function automatic t_num too_big(logic s);
        t_num r;
        if (rmode == fau_pkg::RM_RNE || (rmode == fau_pkg::RM_RUP && !s)
            || (rmode == fau_pkg::RM_RDN && s))
            return mk(fau_pkg::CLS_INF, s);
        r = mk(fau_pkg::CLS_NUM, s);
        r.mant = (64'd1 << (frac_bits() + 1)) - 1;
        r.ex = bias();
        return r;
    endfunction

    function automatic t_num too_small(logic s);
        t_num r;
        if ((rmode == fau_pkg::RM_RUP && !s) || (rmode == fau_pkg::RM_RDN && s)) begin
            r = mk(fau_pkg::CLS_NUM, s);
            r.mant = 64'd1 << frac_bits();
            r.ex = 1 - bias() - frac_bits();
            return r;
        end
        return mk(fau_pkg::CLS_ZERO, s);
    endfunction

    // value = m * 2^q, sticky flags lost nonzero bits below m
    function automatic t_num round_to_format(logic s, int q, logic [63:0] m, logic sticky);
        int   p, e, sh, fl;
        logic rb, st, up;
        t_num r;
        fl = frac_bits();
        p  = msb_pos(m);
        e  = q + p;
        rb = 1'b0;
        st = sticky;
        up = 1'b0;
        if (e > bias()) return too_big(s);
        if (e < 1 - bias() - fl) return too_small(s);
        if (p > fl) begin
            sh = p - fl;
            rb = m[sh-1];
            if (sh > 1 && (m & ((64'd1 << (sh - 1)) - 1)) != 0) st = 1'b1;
            m = m >> sh;
        end else begin
            m = m << (fl - p);
        end
        case (rmode)
            fau_pkg::RM_RNE: up = rb && (st || m[0]);
            fau_pkg::RM_RUP: up = (rb || st) && !s;
            fau_pkg::RM_RDN: up = (rb || st) && s;
            default:         up = 1'b0;
        endcase
        if (up) begin
            m++;
            if ((m >> (fl + 1)) != 0) begin
                m = m >> 1;
                e++;
                if (e > bias()) return too_big(s);
            end
        end
        r = mk(fau_pkg::CLS_NUM, s);
        r.mant = m;
        r.ex = e;
        return r;
    endfunction

    function automatic t_num sum(t_num a, t_num b);
        t_num        x, y;
        int          d;
        logic [63:0] xm, ym, acc;
        logic        s;
        if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN)
            return mk(fau_pkg::CLS_NAN, 1'b0);
        if (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_INF)
            return a.sign == b.sign ? a : mk(fau_pkg::CLS_NAN, 1'b0);
        if (a.cls == fau_pkg::CLS_INF) return a;
        if (b.cls == fau_pkg::CLS_INF) return b;
        if (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_ZERO)
            return mk(fau_pkg::CLS_ZERO,
                      a.sign == b.sign ? a.sign : (rmode == fau_pkg::RM_RDN));
        if (a.cls == fau_pkg::CLS_ZERO) return b;
        if (b.cls == fau_pkg::CLS_ZERO) return a;
        x  = a.ex >= b.ex ? a : b;
        y  = a.ex >= b.ex ? b : a;
        d  = x.ex - y.ex;
        ym = y.mant;
        // far operand collapses to a single sticky bit
        if (d > ALIGN_CAP) begin
            d = ALIGN_CAP;
            ym = 64'd1;
        end
        xm = x.mant << d;
        if (x.sign == y.sign) begin
            acc = xm + ym;
            s = x.sign;
        end else if (xm > ym) begin
            acc = xm - ym;
            s = x.sign;
        end else if (ym > xm) begin
            acc = ym - xm;
            s = y.sign;
        end else begin
            return mk(fau_pkg::CLS_ZERO, rmode == fau_pkg::RM_RDN);
        end
        return round_to_format(s, x.ex - d - frac_bits(), acc, 1'b0);
    endfunction

    function automatic t_num product(t_num a, t_num b);
        logic s;
        s = a.sign ^ b.sign;
        if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN ||
            (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_ZERO) ||
            (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_INF))
            return mk(fau_pkg::CLS_NAN, 1'b0);
        if (a.cls == fau_pkg::CLS_INF || b.cls == fau_pkg::CLS_INF)
            return mk(fau_pkg::CLS_INF, s);
        if (a.cls == fau_pkg::CLS_ZERO || b.cls == fau_pkg::CLS_ZERO)
            return mk(fau_pkg::CLS_ZERO, s);
        return round_to_format(s, a.ex + b.ex - 2 * frac_bits(), a.mant * b.mant, 1'b0);
    endfunction

    function automatic t_num quotient(t_num a, t_num b);
        logic        s;
        logic [63:0] num;
        s = a.sign ^ b.sign;
        if (a.cls == fau_pkg::CLS_NAN || b.cls == fau_pkg::CLS_NAN ||
            (a.cls == fau_pkg::CLS_ZERO && b.cls == fau_pkg::CLS_ZERO) ||
            (a.cls == fau_pkg::CLS_INF && b.cls == fau_pkg::CLS_INF))
            return mk(fau_pkg::CLS_NAN, 1'b0);
        if (a.cls == fau_pkg::CLS_INF || b.cls == fau_pkg::CLS_ZERO)
            return mk(fau_pkg::CLS_INF, s);
        if (a.cls == fau_pkg::CLS_ZERO || b.cls == fau_pkg::CLS_INF)
            return mk(fau_pkg::CLS_ZERO, s);
        num = a.mant << DIV_EXTRA;
        return round_to_format(s, a.ex - b.ex - DIV_EXTRA, num / b.mant,
                               (num % b.mant) != 0);
    endfunction

    function automatic t_result compute_result(logic [2:0] op, logic [63:0] operands);
        t_num    a, b, r;
        t_result o;
        a = unpack_operand(operands[31:0]);
        b = unpack_operand(operands[63:32]);
        case (op)
            fau_pkg::OP_ADD: r = sum(a, b);
            fau_pkg::OP_SUB: begin
                b.sign = ~b.sign;
                r = sum(a, b);
            end
            fau_pkg::OP_MUL: r = product(a, b);
            fau_pkg::OP_DIV: r = quotient(a, b);
            default: r = a;   // pass, also the unused codes
        endcase
        if (r.cls == fau_pkg::CLS_NAN) r.sign = 1'b0;
        o.cls  = r.cls;
        o.sign = r.sign;
        o.ex   = '0;
        o.frac = '0;
        if (r.cls == fau_pkg::CLS_NUM) begin
            o.ex   = r.ex[8:0];
            o.frac = 23'(r.mant - (64'd1 << frac_bits()));
        end
        return o;
    endfunction

    assign o_fail_count = mismatches;

    // Track config, queue predictions, check results
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            prec_sel <= 1'b1;
            rmode    <= fau_pkg::RM_RNE;
            result_fifo.delete();
            mismatches <= 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == fau_pkg::CFG_PREC) prec_sel <= i_cfg_data[0];
                else rmode <= fau_pkg::t_rm'(i_cfg_data);
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                result_fifo.push_back(compute_result(i_s_axis_tuser, i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.cls  = fau_pkg::t_cls'(i_m_axis_tuser);
                got.sign = i_m_axis_tdata[0];
                got.ex   = i_m_axis_tdata[9:1];
                got.frac = i_m_axis_tdata[32:10];
                if (result_fifo.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: cls %0d sign %0d exp %0d frac %h",
                                 got.cls, got.sign, $signed(got.ex), got.frac);
                    mismatches <= mismatches + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (want != got) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected cls %0d sign %0d exp %0d frac %h,",
                                      " got cls %0d sign %0d exp %0d frac %h"},
                                     want.cls, want.sign, $signed(want.ex), want.frac,
                                     got.cls, got.sign, $signed(got.ex), got.frac);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            o_pending <= result_fifo.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Stimulus and verdict for float_arith_unit_half_single: directed corner
// requests, then random requests over all precision/rounding settings.
// Depends on fau_pkg, the unit's RTL and fau_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH  = 33;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    logic        steady;    // no idling on either side
    logic        cur_prec;

    float_arith_unit_half_single dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    fau_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_tready <= steady || ($urandom_range(99) >= 32);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
        // one idle cycle about half the time keeps the sender idle ~32% overall
        if (!steady && $urandom_range(99) < 47) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input fau_pkg::t_cfg_idx idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Operand with a bias toward the interesting encodings
    function automatic logic [31:0] pick_operand(logic prec);
        logic [31:0] raw;
        logic [7:0]  ef;
        logic [22:0] fr;
        int          ew_max;
        int          kind;
        raw    = $urandom;
        kind   = $urandom_range(11);
        ew_max = prec ? 255 : 31;
        fr     = 23'($urandom);
        case (kind)
            4:  ef = 8'd0;                                   // zero or subnormal
            5:  begin ef = 8'd0; fr = '0; end                // zero
            6:  begin ef = 8'(ew_max); fr = '0; end          // infinity
            7:  begin ef = 8'(ew_max); fr[0] = 1'b1; end     // NaN
            8:  ef = ($urandom_range(1) != 0) ? 8'(ew_max - 1) : 8'd1;   // range edges
            9:  ef = 8'($urandom_range(ew_max - 1));
            10: begin ef = 8'(ew_max - 1); fr = '1; end     // largest finite
            11: ef = prec ? 8'($urandom_range(100, 154)) : 8'($urandom_range(10, 20));
            default: return raw;
        endcase
        if (prec) raw = {raw[31], ef, fr};
        else raw[14:0] = {ef[4:0], fr[9:0]};
        return raw;
    endfunction

    task automatic random_burst(input int count);
        logic [2:0]  op;
        logic [31:0] a, b;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(99) < 6) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            a = pick_operand(cur_prec);
            b = pick_operand(cur_prec);
            // near-cancellation for add/sub
            if ((op == fau_pkg::OP_ADD || op == fau_pkg::OP_SUB) && $urandom_range(99) < 20)
            begin
                b = a ^ $urandom_range(3);
                if (op == fau_pkg::OP_ADD) b[cur_prec ? 31 : 15] = ~a[cur_prec ? 31 : 15];
            end
            send(op, a, b);
        end
    endtask

    initial begin
        int rm_seq[8];
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = fau_pkg::OP_PASS;
        cfg_valid = 1'b0;
        cfg_index = fau_pkg::CFG_PREC;
        cfg_data  = '0;
        m_tready  = 1'b0;
        steady    = 1'b0;
        cycles    = 0;
        cur_prec  = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners, single precision, nearest-even
        send(fau_pkg::OP_PASS, 32'h7fc00001, 32'h0);      // NaN
        send(fau_pkg::OP_PASS, 32'hff800000, 32'h0);      // -inf
        send(fau_pkg::OP_PASS, 32'h80000000, 32'h0);      // -0
        send(fau_pkg::OP_PASS, 32'h00000001, 32'h0);      // smallest subnormal
        send(fau_pkg::OP_PASS, 32'h7f7fffff, 32'hffffffff);
        send(3'd7,             32'h3f800000, 32'h40000000);  // unused code acts as pass
        send(fau_pkg::OP_ADD,  32'h7f800000, 32'hff800000);  // inf - inf
        send(fau_pkg::OP_ADD,  32'h00000000, 32'h80000000);  // zeros of opposite sign
        send(fau_pkg::OP_SUB,  32'h3fa00000, 32'h3fa00000);  // exact cancellation
        send(fau_pkg::OP_ADD,  32'h7f7fffff, 32'h73000000);  // rounding carry to overflow
        send(fau_pkg::OP_ADD,  32'h7f000000, 32'h00000001);  // far exponents
        send(fau_pkg::OP_SUB,  32'h00800000, 32'h00000001);
        send(fau_pkg::OP_MUL,  32'h7f800000, 32'h00000000);  // inf * 0
        send(fau_pkg::OP_MUL,  32'h7f7fffff, 32'h7f7fffff);  // overflow
        send(fau_pkg::OP_MUL,  32'h00000001, 32'h80000001);  // underflow
        send(fau_pkg::OP_MUL,  32'h3fffffff, 32'h3fffffff);
        send(fau_pkg::OP_DIV,  32'h00000000, 32'h80000000);  // 0 / 0
        send(fau_pkg::OP_DIV,  32'hbf800000, 32'h00000000);  // -1 / 0
        send(fau_pkg::OP_DIV,  32'h3f800000, 32'h40400000);  // 1 / 3
        send(fau_pkg::OP_DIV,  32'h00000001, 32'h7f7fffff);
        send(fau_pkg::OP_DIV,  32'hffffffff, 32'h3f800000);
        drain();

        // Sweep settings: every mode in both precisions, extremes included
        rm_seq = '{fau_pkg::RM_RTZ, fau_pkg::RM_RDN, fau_pkg::RM_RNE, fau_pkg::RM_RUP,
                   fau_pkg::RM_RDN, fau_pkg::RM_RTZ, fau_pkg::RM_RUP, fau_pkg::RM_RNE};
        for (int ph = 0; ph < 8; ph++) begin
            cur_prec = ph[0];
            write_reg(fau_pkg::CFG_PREC, {1'b0, cur_prec});
            write_reg(fau_pkg::CFG_RMODE, 2'(rm_seq[ph]));
            steady = (ph == 4);
            random_burst(100);
            if (ph == 2) drain();   // hold off until the pipe is empty
            random_burst(100);
            drain();
        end
        steady = 1'b0;

        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: float_arith_unit_half_single.f
sv/fau_pkg.sv
sv/fau_div.sv
sv/float_arith_unit_half_single.sv
sim/fau_checker.sv
sim/tb_top.sv
